FILE: design/cledg_pkg.sv
// Shared types for the credit ledger with FIFO waiters.
package cledg_pkg;

    typedef enum logic [1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_TRY     = 2'd1,
        ACT_RELEASE = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        EV_NOW       = 3'd0,
        EV_WAITER    = 3'd1,
        EV_QUEUED    = 3'd2,
        EV_INVALID   = 3'd3,
        EV_UNAVAIL   = 3'd4,
        EV_FULL      = 3'd5,
        EV_RELEASED  = 3'd6,
        EV_UNDERFLOW = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_READ  = 2'd1,
        S_CHECK = 2'd2
    } t_state;

    localparam int unsigned AMT_W = 16;
    localparam int unsigned TAG_W = 8;

endpackage

FILE: design/credit_ledger_fifo_waiters_unit.sv
// Credit pool with a FIFO queue of blocked acquirers held in one memory.
//
//  channel   direction  handshake                    payload
//  request   in         i_start && !o_busy           i_action, i_amount, i_requester_tag
//  result    out        o_strobe (one cycle, no stall) o_event_res, o_owner_tag,
//                                                    o_granted_amount, o_available_after, o_last
//  config    in         i_cfg_valid && o_cfg_ready   i_cfg_data (pool size)
//
// After an item is applied, the head waiter, if any, is read from the waiter memory in
// S_READ and checked in S_CHECK; every waiter granted is followed by the next read and check.
// The primary result is held until the head waiter has been checked so that its
// last flag is known. Synchronous active-low reset empties the queue, clears the
// outstanding count and sets the pool to 16. The receiver cannot stall results.
module credit_ledger_fifo_waiters_unit #(
    parameter int unsigned WAIT_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_action,
    input  logic [cledg_pkg::AMT_W-1:0] i_amount,
    input  logic [cledg_pkg::TAG_W-1:0] i_requester_tag,
    output logic                        o_strobe,
    output logic [2:0]                  o_event_res,
    output logic [cledg_pkg::TAG_W-1:0] o_owner_tag,
    output logic [cledg_pkg::AMT_W-1:0] o_granted_amount,
    output logic [cledg_pkg::AMT_W-1:0] o_available_after,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cledg_pkg::AMT_W-1:0] i_cfg_data
);
    import cledg_pkg::*;

    localparam int unsigned PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int unsigned ENT_W = TAG_W + AMT_W;

    function automatic logic [AMT_W-1:0] free_of(input logic [AMT_W-1:0] total,
                                                  input logic [AMT_W-1:0] used);
        return (total > used) ? (total - used) : '0;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_state            r_state, n_state;
    logic [AMT_W-1:0]  r_total;
    logic [AMT_W-1:0]  r_outstanding, n_outstanding;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;

    // pending result, held until its last flag is known
    t_event            r_p_event, n_p_event;
    logic [TAG_W-1:0]  r_p_tag, n_p_tag;
    logic [AMT_W-1:0]  r_p_grant, n_p_grant;
    logic [AMT_W-1:0]  r_p_avail, n_p_avail;

    logic [ENT_W-1:0]  r_mem [WAIT_DEPTH];
    logic [ENT_W-1:0]  r_rd_data;
    logic              wr_en;
    logic              rd_en;

    logic [AMT_W-1:0]  free_now;
    logic [AMT_W-1:0]  need;
    logic [TAG_W-1:0]  head_tag;
    logic [AMT_W-1:0]  try_grant;
    logic              strobe;
    logic              last;

    assign free_now  = free_of(r_total, r_outstanding);
    assign need      = r_rd_data[AMT_W-1:0];
    assign head_tag  = r_rd_data[ENT_W-1:AMT_W];
    assign try_grant = (i_amount < free_now) ? i_amount : free_now;

    always_comb begin
        n_state       = r_state;
        n_outstanding = r_outstanding;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_p_event     = r_p_event;
        n_p_tag       = r_p_tag;
        n_p_grant     = r_p_grant;
        n_p_avail     = r_p_avail;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        strobe        = 1'b0;
        last          = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state   = S_READ;
                    n_p_tag   = i_requester_tag;
                    n_p_grant = '0;
                    unique case (i_action)
                        ACT_ACQUIRE: begin
                            if (i_amount == '0 || i_amount > r_total) begin
                                n_p_event = EV_INVALID;
                            end else if (r_count == '0 && free_now >= i_amount) begin
                                n_outstanding = r_outstanding + i_amount;
                                n_p_event     = EV_NOW;
                                n_p_grant     = i_amount;
                            end else if (r_count == CNT_W'(WAIT_DEPTH)) begin
                                n_p_event = EV_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                n_tail    = ptr_inc(r_tail);
                                n_count   = r_count + 1'b1;
                                n_p_event = EV_QUEUED;
                            end
                        end
                        ACT_TRY: begin
                            if (i_amount == '0 || i_amount > r_total) begin
                                n_p_event = EV_INVALID;
                            end else if (free_now == '0) begin
                                n_p_event = EV_UNAVAIL;
                            end else begin
                                n_outstanding = r_outstanding + try_grant;
                                n_p_event     = EV_NOW;
                                n_p_grant     = try_grant;
                            end
                        end
                        ACT_RELEASE: begin
                            if (i_amount > r_outstanding) begin
                                n_outstanding = '0;
                                n_p_event     = EV_UNDERFLOW;
                            end else begin
                                n_outstanding = r_outstanding - i_amount;
                                n_p_event     = EV_RELEASED;
                            end
                        end
                        default: begin
                            n_p_event = EV_INVALID;
                        end
                    endcase
                    n_p_avail = free_of(r_total, n_outstanding);
                end
            end
            S_READ: begin
                if (r_count == '0) begin
                    strobe  = 1'b1;
                    last    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                strobe = 1'b1;
                if (need > free_now) begin
                    last    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // charge the head waiter now and hold its grant as the next result
                    n_outstanding = r_outstanding + need;
                    n_head        = ptr_inc(r_head);
                    n_count       = r_count - 1'b1;
                    n_p_event     = EV_WAITER;
                    n_p_tag       = head_tag;
                    n_p_grant     = need;
                    n_p_avail     = free_now - need;
                    n_state       = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_total       <= AMT_W'(16);
            r_outstanding <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
        end else begin
            r_state       <= n_state;
            r_outstanding <= n_outstanding;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_count       <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_total <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_event <= n_p_event;
        r_p_tag   <= n_p_tag;
        r_p_grant <= n_p_grant;
        r_p_avail <= n_p_avail;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= {i_requester_tag, i_amount};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_cfg_ready       = (r_state == S_IDLE);
    assign o_strobe          = strobe;
    assign o_last            = last;
    assign o_event_res       = r_p_event;
    assign o_owner_tag       = r_p_tag;
    assign o_granted_amount  = r_p_grant;
    assign o_available_after = r_p_avail;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WAIT_DEPTH))
        else $error("waiter count above queue depth");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> r_state == S_IDLE)
        else $error("final result did not return to idle");

    a_waiter_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_event_res == EV_WAITER |-> o_granted_amount != '0)
        else $error("waiter granted zero credit");

    a_waiter_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK && !o_last |=> r_count == $past(r_count) - 1'b1)
        else $error("waiter grant did not pop the queue");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy)
        else $error("result strobed while idle");
`endif

endmodule

FILE: verif/ledger_checker.sv
// Scoreboard for the credit ledger: tracks pool and waiters, checks every result item.
`timescale 1ns / 1ps

module ledger_checker #(
    parameter int unsigned WAIT_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [1:0]                  i_action,
    input  logic [cledg_pkg::AMT_W-1:0] i_amount,
    input  logic [cledg_pkg::TAG_W-1:0] i_requester_tag,
    input  logic                        i_strobe,
    input  logic [2:0]                  i_event_res,
    input  logic [cledg_pkg::TAG_W-1:0] i_owner_tag,
    input  logic [cledg_pkg::AMT_W-1:0] i_granted_amount,
    input  logic [cledg_pkg::AMT_W-1:0] i_available_after,
    input  logic                        i_last,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [cledg_pkg::AMT_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_results
);
    import cledg_pkg::*;

    localparam int unsigned POOL_AT_RESET = 16;

    typedef struct packed {
        t_event           ev;
        logic [TAG_W-1:0] tag;
        logic [AMT_W-1:0] granted;
        logic [AMT_W-1:0] avail;
        logic             last;
    } t_ledger_result;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [AMT_W-1:0] need;
    } t_waiter;

    int unsigned    pool_size;
    int unsigned    held_credit;
    t_waiter        waiter_q[$];
    t_ledger_result due_q[$];
    t_ledger_result want;
    int             fails;
    int             seen;

    // Free credit reads as zero while the pool is shrunk below what is held.
    function automatic int unsigned free_credit();
        return (pool_size > held_credit) ? (pool_size - held_credit) : 0;
    endfunction

    function automatic void note_result(t_event ev, logic [TAG_W-1:0] tag,
                                        int unsigned amt);
        t_ledger_result r;
        r.ev      = ev;
        r.tag     = tag;
        r.granted = amt[AMT_W-1:0];
        r.avail   = AMT_W'(free_credit());
        r.last    = 1'b0;
        due_q.insert(due_q.size(), r);
    endfunction

    function automatic void apply_request(logic [1:0] act, logic [AMT_W-1:0] amt,
                                          logic [TAG_W-1:0] tag);
        int unsigned    grant;
        t_waiter        w;
        t_ledger_result tail;
        case (act)
            ACT_ACQUIRE: begin
                if (amt == 0 || amt > pool_size) begin
                    note_result(EV_INVALID, tag, 0);
                end else if (waiter_q.size() == 0 && free_credit() >= amt) begin
                    held_credit += amt;
                    note_result(EV_NOW, tag, amt);
                end else if (waiter_q.size() >= WAIT_DEPTH) begin
                    note_result(EV_FULL, tag, 0);
                end else begin
                    w.tag  = tag;
                    w.need = amt;
                    waiter_q.insert(waiter_q.size(), w);
                    note_result(EV_QUEUED, tag, 0);
                end
            end
            ACT_TRY: begin
                if (amt == 0 || amt > pool_size) begin
                    note_result(EV_INVALID, tag, 0);
                end else if (free_credit() == 0) begin
                    note_result(EV_UNAVAIL, tag, 0);
                end else begin
                    grant = (amt < free_credit()) ? amt : free_credit();
                    held_credit += grant;
                    note_result(EV_NOW, tag, grant);
                end
            end
            ACT_RELEASE: begin
                if (amt > held_credit) begin
                    held_credit = 0;
                    note_result(EV_UNDERFLOW, tag, 0);
                end else begin
                    held_credit -= amt;
                    note_result(EV_RELEASED, tag, 0);
                end
            end
            default: note_result(EV_INVALID, tag, 0);
        endcase
        // head of the queue is woken after every item, in order, while it fits
        while (waiter_q.size() > 0 && waiter_q[0].need <= free_credit()) begin
            w = waiter_q[0];
            waiter_q.delete(0);
            held_credit += w.need;
            note_result(EV_WAITER, w.tag, w.need);
        end
        tail = due_q[due_q.size() - 1];
        tail.last = 1'b1;
        due_q[due_q.size() - 1] = tail;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pool_size   = POOL_AT_RESET;
            held_credit = 0;
            waiter_q.delete();
            due_q.delete();
            fails = 0;
            seen  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                pool_size = i_cfg_data;
            if (i_start && !i_busy)
                apply_request(i_action, i_amount, i_requester_tag);
            if (i_strobe) begin
                seen++;
                if (due_q.size() == 0) begin
                    $display("%0t: unexpected result ev=%0d tag=%h granted=%0d free=%0d last=%0b",
                             $time, i_event_res, i_owner_tag, i_granted_amount,
                             i_available_after, i_last);
                    fails++;
                end else begin
                    want = due_q[0];
                    due_q.delete(0);
                    if (i_event_res !== want.ev || i_owner_tag !== want.tag ||
                        i_granted_amount !== want.granted ||
                        i_available_after !== want.avail || i_last !== want.last) begin
                        $display("%0t: mismatch expected ev=%0d tag=%h granted=%0d free=%0d last=%0b",
                                 $time, want.ev, want.tag, want.granted, want.avail,
                                 want.last);
                        $display("%0t:          actual   ev=%0d tag=%h granted=%0d free=%0d last=%0b",
                                 $time, i_event_res, i_owner_tag, i_granted_amount,
                                 i_available_after, i_last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_q.size();
        o_results    <= seen;
    end

endmodule

FILE: verif/tb.sv
// Top of the credit ledger testbench: clock, reset, request and pool stimulus, verdict.
`timescale 1ns / 1ps

module tb;
    import cledg_pkg::*;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         PHASE_ITEMS   = 22;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       action;
    logic [AMT_W-1:0] amount;
    logic [TAG_W-1:0] req_tag;
    logic             strobe;
    logic [2:0]       event_res;
    logic [TAG_W-1:0] owner_tag;
    logic [AMT_W-1:0] granted;
    logic [AMT_W-1:0] avail_after;
    logic             last_flag;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [AMT_W-1:0] cfg_data;

    int          fail_count;
    int          pending;
    int          results;
    int          requests;
    int          pool_writes;
    int          quiet_cycles;
    int unsigned pool_now;
    bit          no_idle;

    credit_ledger_fifo_waiters_unit #(
        .WAIT_DEPTH(16)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_action         (action),
        .i_amount         (amount),
        .i_requester_tag  (req_tag),
        .o_strobe         (strobe),
        .o_event_res      (event_res),
        .o_owner_tag      (owner_tag),
        .o_granted_amount (granted),
        .o_available_after(avail_after),
        .o_last           (last_flag),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    ledger_checker #(
        .WAIT_DEPTH(16)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_action         (action),
        .i_amount         (amount),
        .i_requester_tag  (req_tag),
        .i_strobe         (strobe),
        .i_event_res      (event_res),
        .i_owner_tag      (owner_tag),
        .i_granted_amount (granted),
        .i_available_after(avail_after),
        .i_last           (last_flag),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_results        (results)
    );

    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly back to back or short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // start stays high from one item to the next unless a gap is taken
    task automatic issue_request(input logic [1:0] act, input logic [AMT_W-1:0] amt,
                                 input logic [TAG_W-1:0] tag);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        action  <= act;
        amount  <= amt;
        req_tag <= tag;
        do @(posedge clk); while (busy);
        requests++;
    endtask

    // the checker's pending count is a registered copy of its queue size
    task automatic settle_ledger();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pool(input int unsigned size);
        settle_ledger();
        cfg_valid <= 1'b1;
        cfg_data  <= size[AMT_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pool_now = size;
        pool_writes++;
    endtask

    function automatic int unsigned pick_amount();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(1, pool_now);
        return $urandom_range(1, (pool_now < 8) ? pool_now : 8);
    endfunction

    // take the whole pool, overfill the queue, then hand everything back
    task automatic flood_queue();
        int unsigned cap;
        cap = (pool_now / 16 == 0) ? 1 : pool_now / 16;
        issue_request(ACT_ACQUIRE, AMT_W'(pool_now), TAG_W'($urandom_range(0, 255)));
        repeat (18) issue_request(ACT_ACQUIRE, AMT_W'($urandom_range(1, cap)),
                                  TAG_W'($urandom_range(0, 255)));
        issue_request(ACT_RELEASE, 16'hFFFF, TAG_W'($urandom_range(0, 255)));
    endtask

    task automatic random_item();
        int          r;
        int unsigned amt;
        logic [TAG_W-1:0] tag;
        r   = $urandom_range(0, 99);
        tag = TAG_W'($urandom_range(0, 255));
        if (r < 35) begin
            issue_request(ACT_ACQUIRE, AMT_W'(pick_amount()), tag);
        end else if (r < 55) begin
            issue_request(ACT_TRY, AMT_W'(pick_amount()), tag);
        end else if (r < 80) begin
            issue_request(ACT_RELEASE, AMT_W'(pick_amount()), tag);
        end else begin
            case ($urandom_range(0, 4))
                0: issue_request($urandom_range(0, 1) ? ACT_TRY : ACT_ACQUIRE, 0, tag);
                1: begin
                    amt = (pool_now < 65535) ? $urandom_range(pool_now + 1, 65535) : 0;
                    issue_request($urandom_range(0, 1) ? ACT_TRY : ACT_ACQUIRE,
                                  AMT_W'(amt), tag);
                end
                2: issue_request(ACT_UNUSED, AMT_W'($urandom_range(0, 65535)), tag);
                3: issue_request(ACT_RELEASE, AMT_W'($urandom_range(0, 65535)), tag);
                default: issue_request(2'($urandom_range(0, 3)),
                                       AMT_W'($urandom_range(0, 65535)), tag);
            endcase
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        action    <= ACT_ACQUIRE;
        amount    <= '0;
        req_tag   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        requests    = 0;
        pool_writes = 0;
        pool_now    = 16;
        no_idle     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // pool of 16 out of reset: rejects, try, queueing, underflow wake-up
        issue_request(ACT_ACQUIRE, 0, 8'h00);
        issue_request(ACT_ACQUIRE, 17, 8'h01);
        issue_request(ACT_TRY, 0, 8'h02);
        issue_request(ACT_UNUSED, 5, 8'h03);
        issue_request(ACT_RELEASE, 0, 8'h04);
        issue_request(ACT_ACQUIRE, 10, 8'hFF);
        issue_request(ACT_TRY, 10, 8'h05);
        issue_request(ACT_TRY, 1, 8'h06);
        issue_request(ACT_ACQUIRE, 16, 8'h07);
        issue_request(ACT_ACQUIRE, 3, 8'h08);
        issue_request(ACT_RELEASE, 5, 8'h09);
        issue_request(ACT_RELEASE, 16'hFFFF, 8'h0A);
        issue_request(ACT_RELEASE, 16, 8'h0B);

        // widest pool
        set_pool(65535);
        issue_request(ACT_RELEASE, 16'hFFFF, 8'h0C);
        issue_request(ACT_ACQUIRE, 16'hFFFF, 8'hAA);
        issue_request(ACT_ACQUIRE, 1, 8'h55);
        issue_request(ACT_RELEASE, 16'hFFFF, 8'h0D);
        issue_request(ACT_TRY, 16'hFFFF, 8'h0E);
        issue_request(ACT_RELEASE, 16'hFFFF, 8'h0F);

        // shrink under queued waiters, then grow to let the head through
        set_pool(40);
        issue_request(ACT_ACQUIRE, 40, 8'h10);
        issue_request(ACT_ACQUIRE, 30, 8'h11);
        issue_request(ACT_ACQUIRE, 2, 8'h12);
        set_pool(20);
        issue_request(ACT_RELEASE, 10, 8'h13);
        issue_request(ACT_TRY, 5, 8'h14);
        issue_request(ACT_ACQUIRE, 25, 8'h15);
        issue_request(ACT_RELEASE, 30, 8'h16);
        issue_request(ACT_ACQUIRE, 5, 8'h17);
        set_pool(100);
        issue_request(ACT_RELEASE, 0, 8'h18);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_pool(1);
                1: set_pool($urandom_range(2, 300));
                2: set_pool(65535);
                3: set_pool(16);
                default: set_pool($urandom_range(301, 65534));
            endcase
            n = 0;
            while (n < PHASE_ITEMS) begin
                no_idle = ($urandom_range(0, 3) == 0);
                if (n == 0 || $urandom_range(0, 9) == 0) begin
                    flood_queue();
                    n += 20;
                end else begin
                    random_item();
                    n++;
                end
                if ($urandom_range(0, 19) == 0)
                    settle_ledger();
            end
        end

        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Run: %0d requests over %0d pool settings from 1 to 65535, %0d results checked",
                 requests, pool_writes, results);
        $display("Covered invalid, try, queue full, underflow and multi-waiter wake-ups");
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
